[sv/ccp_pkg.sv]
// Shared types and constants for the CRC codeword packer.
package ccp_pkg;

    localparam int BYTE_W      = 8;
    localparam int GEN_W       = 17;
    localparam int DEGREE_W    = 5;
    localparam int MSG_W       = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [GEN_W-1:0]    GEN_RESET    = 17'd11;
    localparam logic [DEGREE_W-1:0] DEGREE_RESET = 5'd3;
    localparam logic                MODE_RESET   = 1'b1;
    localparam logic [MSG_W-1:0]    MSG_RESET    = 16'd1;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_GEN_POLY   = 4'd0,
        REG_CRC_DEGREE = 4'd1,
        REG_DW_MODE    = 4'd2,
        REG_MSG_BYTES  = 4'd3
    } cfg_reg_t;

endpackage

[sv/ccp_fifo.sv]
// Small first-in first-out queue between the codeword front end and the byte packer.
module ccp_fifo #(
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    import ccp_pkg::*;

    logic [WIDTH-1:0]    mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   cnt_reg;
    logic [QUEUE_AW:0]   cnt_next;
    logic                do_wr;
    logic                do_rd;

    assign full    = (cnt_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[sv/ccp_front.sv]
// Front end: configuration registers, message framing and CRC codeword generation.
module ccp_front #(
    parameter int MAX_DEGREE = 16,
    parameter int ENTRY_W    = 56,
    parameter int LEN_W      = 6,
    parameter int QW         = 63
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [ccp_pkg::BYTE_W-1:0]      data_byte,
    input  logic                            cfg_valid,
    input  logic [ccp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            q_wr_en,
    output logic [QW-1:0]                   q_wr_data,
    input  logic                            q_full
);
    import ccp_pkg::*;

    localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
    localparam int CW_W    = 8 + MAX_DEGREE;
    localparam int CALC_W  = CW_W + GEN_W;
    localparam int PIECE_W = $clog2(CW_W + 1);
    localparam int CW2_W   = 2 * CW_W;

    logic [GEN_W-1:0]    gen_reg;
    logic [DEGREE_W-1:0] degree_reg;
    logic                mode_reg;
    logic [MSG_W-1:0]    msg_reg;
    logic [MSG_W-1:0]    seen_reg;
    logic [MSG_W-1:0]    seen_next;
    logic [MSG_W-1:0]    seen_inc;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [CW_W-1:0]     s1_cw_a_reg;
    logic [CW_W-1:0]     s1_cw_b_reg;
    logic [PIECE_W-1:0]  s1_piece_reg;
    logic                s1_two_reg;
    logic                s1_hdr_reg;
    logic [3:0]          s1_pad_reg;
    logic                s1_last_reg;

    logic                accept;
    logic [DEG_W-1:0]    n;
    logic [CALC_W-1:0]   poly;
    logic [CW_W-1:0]     cw_byte;
    logic [CW_W-1:0]     cw_hi;
    logic [CW_W-1:0]     cw_lo;
    logic [2:0]          per3;
    logic [2:0]          rem3;
    logic [3:0]          pad;
    logic                is_hdr;
    logic                is_last;

    logic [CW2_W-1:0]    cw_val;
    logic [LEN_W-1:0]    cw_len;
    logic [LEN_W-1:0]    hdr_len;
    logic [ENTRY_W-1:0]  hdr_vec;
    logic [ENTRY_W-1:0]  cw_left;

    function automatic logic [CW_W-1:0] crc_codeword(
        input logic [7:0]        d,
        input logic              wide,
        input logic [DEG_W-1:0]  deg,
        input logic [CALC_W-1:0] gen
    );
        logic [CALC_W-1:0] dext;
        logic [CALC_W-1:0] r;
        logic [CALC_W-1:0] mask;
        int                w;
        int                pos;
        w    = wide ? 8 : 4;
        dext = CALC_W'(d) << deg;
        r    = dext;
        for (int j = 0; j < 8; j++)
        begin
            if (j < w)
            begin
                pos = w + int'(deg) - 1 - j;
                if (r[pos])
                begin
                    r = r ^ (gen << (w - 1 - j));
                end
            end
        end
        mask = (CALC_W'(1) << deg) - CALC_W'(1);
        return CW_W'(dext | (r & mask));
    endfunction

    assign full   = s1_valid_reg && q_full;
    assign accept = push && !full;

    always_comb
    begin
        if (32'(degree_reg) > MAX_DEGREE)
        begin
            n = DEG_W'(MAX_DEGREE);
        end
        else
        begin
            n = DEG_W'(degree_reg);
        end
    end

    assign poly = CALC_W'(gen_reg) & ((CALC_W'(1) << (32'(n) + 32'd1)) - CALC_W'(1));

    assign cw_byte = crc_codeword(data_byte, 1'b1, n, poly);
    assign cw_hi   = crc_codeword({4'b0, data_byte[7:4]}, 1'b0, n, poly);
    assign cw_lo   = crc_codeword({4'b0, data_byte[3:0]}, 1'b0, n, poly);

    assign per3    = mode_reg ? 3'(32'(n)) : 3'(32'(n) * 2);
    assign rem3    = 3'(msg_reg[2:0] * per3);
    assign pad     = 4'd8 - {1'b0, rem3};
    assign is_hdr  = (seen_reg == '0);
    assign seen_inc = seen_reg + 1'b1;
    assign is_last = (seen_inc == msg_reg);
    assign seen_next = is_last ? '0 : seen_inc;

    always_comb
    begin
        q_wr_en       = s1_valid_reg && !q_full;
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_wr_en)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg      <= GEN_RESET;
            degree_reg   <= DEGREE_RESET;
            mode_reg     <= MODE_RESET;
            msg_reg      <= MSG_RESET;
            seen_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                seen_reg <= seen_next;
            end
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_GEN_POLY:   gen_reg    <= cfg_data[GEN_W-1:0];
                    REG_CRC_DEGREE: degree_reg <= cfg_data[DEGREE_W-1:0];
                    REG_DW_MODE:    mode_reg   <= cfg_data[0];
                    REG_MSG_BYTES:  msg_reg    <= cfg_data[MSG_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cw_a_reg  <= mode_reg ? cw_byte : cw_hi;
            s1_cw_b_reg  <= cw_lo;
            s1_piece_reg <= PIECE_W'(32'(n) + (mode_reg ? 32'd8 : 32'd4));
            s1_two_reg   <= !mode_reg;
            s1_hdr_reg   <= is_hdr;
            s1_pad_reg   <= pad;
            s1_last_reg  <= is_last;
        end
    end

    always_comb
    begin
        if (s1_two_reg)
        begin
            cw_val = (CW2_W'(s1_cw_a_reg) << s1_piece_reg) | CW2_W'(s1_cw_b_reg);
            cw_len = LEN_W'(s1_piece_reg) << 1;
        end
        else
        begin
            cw_val = CW2_W'(s1_cw_a_reg);
            cw_len = LEN_W'(s1_piece_reg);
        end
        if (s1_hdr_reg)
        begin
            hdr_len = LEN_W'(s1_pad_reg) + LEN_W'(8);
            hdr_vec = ENTRY_W'(s1_pad_reg) << (ENTRY_W - 8);
        end
        else
        begin
            hdr_len = '0;
            hdr_vec = '0;
        end
        cw_left   = (ENTRY_W'(cw_val) << (LEN_W'(ENTRY_W) - cw_len)) >> hdr_len;
        q_wr_data = {s1_last_reg, LEN_W'(hdr_len + cw_len), hdr_vec | cw_left};
    end

endmodule

[sv/ccp_back.sv]
// Back end: bit buffer that packs queued codeword bits into output bytes.
module ccp_back #(
    parameter int ENTRY_W = 56,
    parameter int LEN_W   = 6,
    parameter int QW      = 63
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [QW-1:0]               q_rd_data,
    input  logic                        q_empty,
    output logic                        q_rd_en,
    output logic                        empty,
    input  logic                        pop,
    output logic [ccp_pkg::BYTE_W-1:0]  out_byte,
    output logic                        run_last,
    output logic                        stream_last
);
    import ccp_pkg::*;

    localparam int BUF_W = ENTRY_W + 8;
    localparam int CNT_W = $clog2(BUF_W + 1);

    logic [BUF_W-1:0]  buf_reg;
    logic [BUF_W-1:0]  buf_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              flush_reg;
    logic              flush_next;
    logic              ovalid_reg;
    logic              ovalid_next;
    logic [7:0]        obyte_reg;
    logic              orun_reg;
    logic              olast_reg;

    logic              slot_free;
    logic              emit;
    logic              tail;
    logic [BUF_W-1:0]  buf_a;
    logic [CNT_W-1:0]  cnt_a;
    logic              flush_a;
    logic              q_last;
    logic [LEN_W-1:0]  q_len;
    logic [ENTRY_W-1:0] q_entry;

    assign q_last  = q_rd_data[QW-1];
    assign q_len   = q_rd_data[ENTRY_W +: LEN_W];
    assign q_entry = q_rd_data[ENTRY_W-1:0];

    assign empty       = !ovalid_reg;
    assign out_byte    = obyte_reg;
    assign run_last    = orun_reg;
    assign stream_last = olast_reg;

    always_comb
    begin
        slot_free = !ovalid_reg || pop;
        tail      = (cnt_reg <= CNT_W'(8));
        emit      = slot_free && ((cnt_reg >= CNT_W'(8)) || (flush_reg && cnt_reg != '0));
        if (emit)
        begin
            buf_a = buf_reg << 8;
            cnt_a = tail ? '0 : cnt_reg - CNT_W'(8);
        end
        else
        begin
            buf_a = buf_reg;
            cnt_a = cnt_reg;
        end
        flush_a = flush_reg && !(emit && tail);
        q_rd_en = !q_empty && (cnt_a < CNT_W'(8)) && !flush_a;
        if (q_rd_en)
        begin
            buf_next   = buf_a | ({q_entry, 8'b0} >> cnt_a);
            cnt_next   = cnt_a + CNT_W'(q_len);
            flush_next = flush_a || q_last;
        end
        else
        begin
            buf_next   = buf_a;
            cnt_next   = cnt_a;
            flush_next = flush_a;
        end
        ovalid_next = emit ? 1'b1 : (pop ? 1'b0 : ovalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg    <= '0;
            cnt_reg    <= '0;
            flush_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            buf_reg    <= buf_next;
            cnt_reg    <= cnt_next;
            flush_reg  <= flush_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            obyte_reg <= buf_reg[BUF_W-1 -: 8];
            orun_reg  <= flush_reg ? tail : (cnt_reg < CNT_W'(16));
            olast_reg <= flush_reg && tail;
        end
    end

endmodule

[sv/crc_codeword_packer_top.sv]
// Top level of the CRC codeword packer.
//
//   Channel   Handshake                Payload
//   input     push / full              data_byte
//   result    empty / pop              out_byte, run_last, stream_last
//   config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// The front end takes one byte per cycle, unless a full queue holds its stage, and computes
// its codewords; the packer behind a four-entry queue sends one output byte per cycle while
// the receiver keeps popping. A codeword is registered in the front end, then written into
// the queue and read by the packer. Reset clears the configuration to its defaults and
// empties all stages. Either side may stall independently; cfg_ready is always high.
module crc_codeword_packer_top #(
    parameter int MAX_DEGREE = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [ccp_pkg::BYTE_W-1:0]      data_byte,
    output logic                            empty,
    input  logic                            pop,
    output logic [ccp_pkg::BYTE_W-1:0]      out_byte,
    output logic                            run_last,
    output logic                            stream_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ccp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ccp_pkg::*;

    localparam int ENTRY_W = 24 + 2 * MAX_DEGREE;
    localparam int LEN_W   = $clog2(ENTRY_W + 1);
    localparam int QW      = 1 + LEN_W + ENTRY_W;

    logic          q_wr_en;
    logic [QW-1:0] q_wr_data;
    logic          q_full;
    logic          q_rd_en;
    logic [QW-1:0] q_rd_data;
    logic          q_empty;

    assign cfg_ready = 1'b1;

    ccp_front #(
        .MAX_DEGREE (MAX_DEGREE),
        .ENTRY_W    (ENTRY_W),
        .LEN_W      (LEN_W),
        .QW         (QW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data),
        .q_full    (q_full)
    );

    ccp_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    ccp_back #(
        .ENTRY_W (ENTRY_W),
        .LEN_W   (LEN_W),
        .QW      (QW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_rd_data   (q_rd_data),
        .q_empty     (q_empty),
        .q_rd_en     (q_rd_en),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .stream_last (stream_last)
    );

endmodule

[tb/sv/tb_crc_codeword_packer_top.sv]
// Self-checking testbench for the CRC codeword packer: byte-stream predictor with randomized flow control.
`timescale 1ns / 1ps

module tb_crc_codeword_packer_top;

    import ccp_pkg::*;

    localparam int MAX_DEG        = 16;
    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_TARGET  = 200;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_end;
        logic              stream_end;
    } packed_byte_t;

    class codeword_stream_model;
        logic [GEN_W-1:0]    gen_poly;
        logic [DEGREE_W-1:0] degree;
        logic                word_mode;
        logic [MSG_W-1:0]    msg_len;
        logic [MSG_W-1:0]    bytes_taken;
        logic [63:0]         bit_acc;
        int                  acc_bits;
        packed_byte_t        expected_bytes[$];
        int                  errors;
        int                  bytes_in;
        int                  bytes_out;

        function new();
            gen_poly    = GEN_RESET;
            degree      = DEGREE_RESET;
            word_mode   = MODE_RESET;
            msg_len     = MSG_RESET;
            bytes_taken = '0;
            bit_acc     = '0;
            acc_bits    = 0;
            errors      = 0;
            bytes_in    = 0;
            bytes_out   = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_GEN_POLY:   gen_poly = value[GEN_W-1:0];
                REG_CRC_DEGREE: degree = value[DEGREE_W-1:0];
                REG_DW_MODE:    word_mode = value[0];
                REG_MSG_BYTES:  msg_len = value[MSG_W-1:0];
                default:        ;
            endcase
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void flag_error(string what);
            errors++;
            if (errors <= 10)
                $display("[%0t] MISMATCH: %s", $time, what);
        endfunction

        function void append_bits(logic [63:0] value, int count);
            packed_byte_t b;
            if (count == 0)
                return;
            bit_acc = (bit_acc << count) | (value & ((64'd1 << count) - 64'd1));
            acc_bits += count;
            while (acc_bits >= 8) begin
                b.data       = 8'(bit_acc >> (acc_bits - 8));
                b.run_end    = 1'b0;
                b.stream_end = 1'b0;
                expected_bytes.insert(expected_bytes.size(), b);
                acc_bits -= 8;
                bit_acc &= (64'd1 << acc_bits) - 64'd1;
            end
        endfunction

        function logic [63:0] crc_codeword(logic [7:0] word, int width, int n);
            logic [63:0] poly;
            logic [63:0] rem;
            int          pos;
            poly = 64'(gen_poly) & ((64'd1 << (n + 1)) - 64'd1);
            rem  = 64'(word) << n;
            for (int j = 0; j < width; j++) begin
                pos = width + n - 1 - j;
                if (rem[pos])
                    rem ^= poly << (width - 1 - j);
            end
            return (64'(word) << n) | (rem & ((64'd1 << n) - 64'd1));
        endfunction

        function void note_byte(logic [BYTE_W-1:0] value);
            int   n;
            int   per;
            int   pad;
            int   first;
            int   last_idx;
            logic done;
            n     = (degree > MAX_DEG) ? MAX_DEG : int'(degree);
            first = expected_bytes.size();
            if (bytes_taken == '0) begin
                per = (word_mode ? 1 : 2) * ((word_mode ? 8 : 4) + n);
                pad = 8 - ((int'(msg_len[2:0]) * per) & 7);
                append_bits(64'(pad), 8);
                append_bits(64'd0, pad);
            end
            if (word_mode) begin
                append_bits(crc_codeword(value, 8, n), 8 + n);
            end
            else begin
                append_bits(crc_codeword({4'd0, value[7:4]}, 4, n), 4 + n);
                append_bits(crc_codeword({4'd0, value[3:0]}, 4, n), 4 + n);
            end
            bytes_taken = bytes_taken + 16'd1;
            done = (bytes_taken == msg_len);
            if (done) begin
                if (acc_bits > 0)
                    append_bits(64'd0, 8 - acc_bits);
                bytes_taken = '0;
                bit_acc     = '0;
                acc_bits    = 0;
            end
            if (expected_bytes.size() > first) begin
                last_idx = expected_bytes.size() - 1;
                expected_bytes[last_idx].run_end    = 1'b1;
                expected_bytes[last_idx].stream_end = done;
            end
            bytes_in++;
        endfunction

        function void check_byte(logic [BYTE_W-1:0] data, logic run_end, logic stream_end);
            packed_byte_t want;
            bytes_out++;
            if (expected_bytes.size() == 0) begin
                flag_error($sformatf("output byte %02h (run_last %b, stream_last %b) %s",
                                     data, run_end, stream_end, "with nothing expected"));
                return;
            end
            want = expected_bytes.pop_front();
            if (want.data !== data || want.run_end !== run_end || want.stream_end !== stream_end)
                flag_error($sformatf("expected byte %02h run_last %b stream_last %b, got %02h %b %b",
                                     want.data, want.run_end, want.stream_end,
                                     data, run_end, stream_end));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    logic [BYTE_W-1:0]     data_byte   = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    logic [BYTE_W-1:0]     out_byte;
    logic                  run_last;
    logic                  stream_last;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    bit quiet        = 1'b0;
    bit hold_request = 1'b0;
    int idle_cycles  = 0;
    int settings_used = 0;

    codeword_stream_model stream_model = new();

    crc_codeword_packer_top #(
        .MAX_DEGREE(MAX_DEG)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .stream_last (stream_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (push && !full)
                stream_model.note_byte(data_byte);
            if (pop && !empty)
                stream_model.check_byte(out_byte, run_last, stream_last);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[%0t] Watchdog: no transfer for %0d cycles, %0d bytes still expected.",
                     $time, WATCHDOG_LIMIT, stream_model.pending());
            $display("end of test: mismatches");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(25, 60);
    endfunction

    initial
    begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_request) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                gap = quiet ? 0 : pick_gap();
                if (gap > 0) begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] value);
        int gap;
        push      <= 1'b1;
        data_byte <= value;
        @(posedge clk);
        while (full) @(posedge clk);
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (stream_model.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        stream_model.set_register(idx, value);
    endtask

    task automatic configure(input logic [GEN_W-1:0] gen, input logic [DEGREE_W-1:0] deg,
                             input logic mode, input logic [MSG_W-1:0] len);
        write_register(REG_GEN_POLY, CFG_DATA_W'(gen));
        write_register(REG_CRC_DEGREE, CFG_DATA_W'(deg));
        write_register(REG_DW_MODE, CFG_DATA_W'(mode));
        write_register(REG_MSG_BYTES, CFG_DATA_W'(len));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic pick_settings(output logic [GEN_W-1:0] gen, output logic [DEGREE_W-1:0] deg,
                                 output logic mode, output logic [MSG_W-1:0] len);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            deg = DEGREE_W'($urandom_range(17, 31));
        else if (r == 1)
            deg = '0;
        else if (r == 2)
            deg = DEGREE_W'(16);
        else
            deg = DEGREE_W'($urandom_range(1, 16));
        gen = GEN_W'($urandom_range(0, 17'h1FFFF));
        if (deg <= 16 && $urandom_range(0, 9) != 0)
            gen = gen | (17'd1 << deg);
        mode = 1'($urandom_range(0, 1));
        len  = ($urandom_range(0, 4) == 0) ? MSG_W'($urandom_range(9, 40))
                                            : MSG_W'($urandom_range(1, 8));
    endtask

    initial
    begin
        logic [GEN_W-1:0]    gen;
        logic [DEGREE_W-1:0] deg;
        logic                mode;
        logic [MSG_W-1:0]    len;
        int                  random_bytes;
        int                  open_left;
        int                  count;
        int                  extra;

        random_bytes = 0;
        open_left    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: each byte is a whole message, so every byte opens a new stream.
        send_byte(8'h00);
        send_byte(8'hFF);

        wait_idle();
        configure(17'h11021, 5'd16, 1'b0, 16'd3);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'hFF);

        wait_idle();
        configure(17'h1FFFF, 5'd1, 1'b1, 16'd2);
        send_byte(8'h80);
        send_byte(8'h01);

        wait_idle();
        configure(17'h00005, 5'd4, 1'b0, 16'd2);
        send_byte(8'hF0);
        send_byte(8'h0F);

        wait_idle();
        configure(17'h00000, 5'd0, 1'b0, 16'd2);
        send_byte(8'h12);
        send_byte(8'h34);

        wait_idle();
        configure(17'h18005, 5'd31, 1'b1, 16'd1);
        send_byte(8'hC3);

        // Settings change in the middle of a message; the header keeps its pad count.
        wait_idle();
        configure(17'h00007, 5'd2, 1'b1, 16'hFFFF);
        send_byte(8'h3C);
        send_byte(8'hE7);
        send_byte(8'h18);
        wait_idle();
        write_register(REG_MSG_BYTES, CFG_DATA_W'(5));
        write_register(REG_CRC_DEGREE, CFG_DATA_W'(5));
        write_register(REG_GEN_POLY, CFG_DATA_W'(17'h00025));
        write_register(REG_DW_MODE, CFG_DATA_W'(0));
        cfg_valid <= 1'b0;
        settings_used++;
        send_byte(8'h96);
        send_byte(8'h69);

        // Receiver stalls while the sender keeps offering, so the input side backs up.
        wait_idle();
        configure(17'h11021, 5'd16, 1'b0, 16'd6);
        hold_request = 1'b1;
        repeat (12) send_byte(8'($urandom_range(0, 255)));

        // A zero length register opens a stream with a full byte of padding; the
        // message is then closed by a shorter length written partway through.
        wait_idle();
        configure(17'h00001, 5'd0, 1'b1, 16'd0);
        quiet = 1'b1;
        repeat (5) send_byte(8'($urandom_range(0, 255)));
        wait_idle();
        quiet = 1'b0;
        write_register(REG_MSG_BYTES, CFG_DATA_W'(7));
        cfg_valid <= 1'b0;
        settings_used++;
        repeat (2) send_byte(8'($urandom_range(0, 255)));

        while (random_bytes < RANDOM_TARGET) begin
            wait_idle();
            pick_settings(gen, deg, mode, len);
            if (open_left > 0) begin
                write_register(REG_GEN_POLY, CFG_DATA_W'(gen));
                write_register(REG_CRC_DEGREE, CFG_DATA_W'(deg));
                write_register(REG_DW_MODE, CFG_DATA_W'(mode));
                cfg_valid <= 1'b0;
                settings_used++;
                count     = open_left;
                open_left = 0;
            end
            else begin
                configure(gen, deg, mode, len);
                count = int'(len) * $urandom_range(1, 3);
                if (len > 1 && $urandom_range(0, 3) == 0) begin
                    extra     = $urandom_range(1, int'(len) - 1);
                    count    += extra;
                    open_left = int'(len) - extra;
                end
            end
            repeat (count) begin
                send_byte(8'($urandom_range(0, 255)));
                random_bytes++;
            end
        end

        wait_idle();
        repeat (16) @(posedge clk);
        $display("Covered %0d input bytes and %0d output bytes over %0d register settings,",
                 stream_model.bytes_in, stream_model.bytes_out, settings_used);
        $display("including mid-message changes, a zero length setting and a long output stall.");
        if (stream_model.errors == 0 && stream_model.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
